### hdl/dltq_pkg.sv
package dltq_pkg;

  // most expiries reported for one tick
  localparam int MAX_OUT = 8;
  localparam int NW      = $clog2(MAX_OUT + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_code_t   cmd;
    logic [15:0] wait_time;
    logic [7:0]  tag;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] slot;
    logic [7:0] expired_tag;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_RESP,
    ST_SCAN,
    ST_EXPIRE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start_claim;
    logic start_reject;
    logic tick_start;
    logic ins_step;
    logic load_resp;
    logic scan_step;
    logic exp_step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic ins_done;
    logic scan_done;
    logic scan_none;
    logic exp_last;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/dltq_ctrl.sv
module dltq_ctrl
  import dltq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  cmd_code_t  in_cmd,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_START) begin
            state_next = status.full ? ST_RESP : ST_INSERT;
          end else if (!status.empty) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_INSERT: begin
        if (status.ins_done) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = status.scan_none ? ST_IDLE : ST_EXPIRE;
      end
      ST_EXPIRE: begin
        if (status.out_free && status.exp_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_START) begin
            cmd.start_claim  = !status.full;
            cmd.start_reject = status.full;
          end else begin
            cmd.tick_start = !status.empty;
          end
        end
      end
      ST_INSERT: cmd.ins_step  = 1'b1;
      ST_RESP:   cmd.load_resp = status.out_free;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_EXPIRE: cmd.exp_step  = status.out_free;
      default: ;
    endcase
  end

endmodule

### hdl/dltq_dp.sv
module dltq_dp
  import dltq_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  in_item_t   in_data,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // list kept by position, head (soonest) at count-1
  logic [15:0]   delta_pos [SLOTS];
  logic [SW-1:0] order_pos [SLOTS];
  logic [7:0]    slot_tag  [SLOTS];

  logic [CW-1:0]    count;
  logic [SLOTS-1:0] free_mask;

  logic [SW-1:0] pos;
  logic [15:0]   rel;
  logic [SW-1:0] ins_slot;
  logic          rejected;
  logic          dec_done;
  logic          counting;
  logic [NW-1:0] n_exp;

  logic [SW-1:0] free_slot;
  logic [SW-1:0] pos_m1;
  logic [CW-1:0] cm1;
  logic [SW-1:0] head;
  logic [SW-1:0] d_addr;
  logic [SW-1:0] o_addr;
  logic [15:0]   d_rd;
  logic [SW-1:0] o_rd;
  logic          ins_at_zero;
  logic          ins_shift;
  logic          dec_now;
  logic          dec_new;
  logic          zero_now;
  logic          count_ok;
  logic [NW-1:0] n_next;
  logic [SW+2:0] ins_ext;
  logic [SW+2:0] exp_ext;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (free_mask[k]) free_slot = SW'(k);
    end
  end

  // single read port on each list array
  assign pos_m1 = pos - 1'b1;
  assign cm1    = count - 1'b1;
  assign head   = cm1[SW-1:0];
  assign d_addr = cmd.ins_step ? pos_m1 : pos;
  assign o_addr = cmd.ins_step ? pos_m1 : head;
  assign d_rd   = delta_pos[d_addr];
  assign o_rd   = order_pos[o_addr];

  // insertion walk: move past entries that expire strictly sooner
  assign ins_at_zero = (pos == '0);
  assign ins_shift   = !ins_at_zero && (d_rd < rel);

  // tick scan: take the millisecond from the first nonzero delta, count zeros at the head
  assign dec_now  = !dec_done && (d_rd != 16'd0);
  assign dec_new  = dec_done || (d_rd != 16'd0);
  assign zero_now = dec_done ? (d_rd == 16'd0) : (d_rd <= 16'd1);
  assign count_ok = counting && zero_now && (n_exp != NW'(MAX_OUT));
  assign n_next   = n_exp + NW'(count_ok);

  assign ins_ext = {3'b000, ins_slot};
  assign exp_ext = {3'b000, o_rd};

  always_comb begin
    status           = '0;
    status.full      = (count == CW'(SLOTS));
    status.empty     = (count == '0);
    status.ins_done  = !ins_shift;
    status.scan_done = (pos == '0) || (dec_new && !count_ok);
    status.scan_none = (n_next == '0);
    status.exp_last  = (n_exp == NW'(1));
    status.out_free  = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      free_mask <= '1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start_claim) begin
        count               <= count + 1'b1;
        free_mask[free_slot] <= 1'b0;
      end else if (cmd.exp_step) begin
        count          <= cm1;
        free_mask[o_rd] <= 1'b1;
      end
      if (cmd.load_resp || cmd.exp_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // list, tags and work registers
  always_ff @(posedge clk) begin
    if (cmd.start_claim) begin
      slot_tag[free_slot] <= in_data.tag;
      ins_slot            <= free_slot;
      rel                 <= in_data.wait_time;
      pos                 <= count[SW-1:0];
      rejected            <= 1'b0;
    end
    if (cmd.start_reject) begin
      rejected <= 1'b1;
    end
    if (cmd.tick_start) begin
      pos      <= head;
      dec_done <= 1'b0;
      counting <= 1'b1;
      n_exp    <= '0;
    end
    if (cmd.ins_step) begin
      if (ins_at_zero) begin
        order_pos[0] <= ins_slot;
        delta_pos[0] <= rel;
      end else if (ins_shift) begin
        order_pos[pos] <= o_rd;
        delta_pos[pos] <= d_rd;
        rel            <= rel - d_rd;
        pos            <= pos_m1;
      end else begin
        delta_pos[pos_m1] <= d_rd - rel;
        order_pos[pos]    <= ins_slot;
        delta_pos[pos]    <= rel;
      end
    end
    if (cmd.scan_step) begin
      if (dec_now) delta_pos[pos] <= d_rd - 16'd1;
      dec_done <= dec_new;
      counting <= count_ok;
      n_exp    <= n_next;
      pos      <= pos_m1;
    end
    if (cmd.load_resp) begin
      if (rejected) begin
        out_data <= '{kind: KIND_FULL, slot: 3'd0, expired_tag: 8'd0, last: 1'b1};
      end else begin
        out_data <= '{kind: KIND_ACCEPT, slot: ins_ext[2:0], expired_tag: 8'd0, last: 1'b1};
      end
    end
    if (cmd.exp_step) begin
      out_data <= '{kind: KIND_EXPIRED, slot: exp_ext[2:0], expired_tag: slot_tag[o_rd],
                    last: status.exp_last};
      n_exp    <= n_exp - 1'b1;
    end
  end

  // every slot is either free or on the list
  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    ($countones(free_mask) + int'(count)) == SLOTS)
    else $error("free mask and entry count disagree");

  // only a zero-delta head expires
  a_head_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.exp_step |-> (count != '0) && (delta_pos[head] == 16'd0))
    else $error("expiry of a head with nonzero delta");

  // a scan never begins on an empty list
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_start |-> (count != '0))
    else $error("tick scan started on empty list");

  // result register is loaded only when free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_resp || cmd.exp_step) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // an expiry step shows an expired result next cycle
  a_exp_kind: assert property (@(posedge clk) disable iff (rst)
    cmd.exp_step |=> out_valid && (out_data.kind == KIND_EXPIRED))
    else $error("expiry step without expired result");

endmodule

### hdl/delta_list_timer_queue_unit.sv
// Delta-list one-shot timer queue with SLOTS slots. A start item claims the lowest free
// slot, stores its tag and walks the sorted list from the head toward the tail, one entry
// per cycle, and then loads the single result (accepted with slot) into the output
// register; a start on a full queue skips the walk and goes straight to loading its full
// result. A tick item scans from the head one entry per cycle until the millisecond has
// been taken from the first nonzero delta and the run of zero deltas has ended or reached
// MAX_OUT, then emits one expiry per cycle while the output register is free, soonest
// first, with last set on the final one; a tick that expires nothing, or arrives on an
// empty list, gives no result. Every result load waits while the output register still
// holds a result that has not been taken. The next item is taken once the previous one
// has finished its walk or its last result is in the output register.
module delta_list_timer_queue_unit
  import dltq_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // list storage and result register
  dltq_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/timer_queue_checker.sv
`timescale 1ns / 1ps

module timer_queue_checker
  import dltq_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        outstanding
);

  // shadow copy of the delta list; head sits at position live_count-1
  logic [15:0]      rel_ms       [SLOTS];
  logic [2:0]       expiry_order [SLOTS];
  logic [7:0]       slot_label   [SLOTS];
  logic [SLOTS-1:0] free_slots;
  int               live_count;
  out_item_t        pending_reports [$];

  task automatic report_mismatch(string msg);
    $display("%0t ns timer queue check: %s", $time, msg);
    errors++;
  endtask

  function automatic void queue_report(kind_t k, logic [2:0] s, logic [7:0] t, logic l);
    out_item_t r;
    r.kind        = k;
    r.slot        = s;
    r.expired_tag = t;
    r.last        = l;
    pending_reports.push_back(r);
  endfunction

  // claim lowest free slot and insert it by expiry, ties go sooner
  task automatic predict_start(logic [15:0] wait_ms, logic [7:0] label);
    logic [15:0] rel;
    int          pos;
    int          s;
    if (live_count >= SLOTS) begin
      queue_report(KIND_FULL, 3'd0, 8'd0, 1'b1);
      return;
    end
    s = 0;
    while (!free_slots[s]) s++;
    free_slots[s] = 1'b0;
    slot_label[s] = label;
    rel = wait_ms;
    pos = live_count;
    while (pos > 0 && rel_ms[expiry_order[pos-1]] < rel) begin
      rel = rel - rel_ms[expiry_order[pos-1]];
      expiry_order[pos] = expiry_order[pos-1];
      pos--;
    end
    if (pos > 0) rel_ms[expiry_order[pos-1]] = rel_ms[expiry_order[pos-1]] - rel;
    expiry_order[pos] = s[2:0];
    rel_ms[s] = rel;
    live_count++;
    queue_report(KIND_ACCEPT, s[2:0], 8'd0, 1'b1);
  endtask

  // one millisecond off the first nonzero delta, then expire the zero run at the head
  task automatic predict_tick();
    int        p;
    int        n;
    int        s;
    out_item_t tail;
    for (p = live_count; p > 0; p--) begin
      if (rel_ms[expiry_order[p-1]] != 16'd0) begin
        rel_ms[expiry_order[p-1]] = rel_ms[expiry_order[p-1]] - 16'd1;
        break;
      end
    end
    n = 0;
    while (live_count > 0 && n < MAX_OUT && rel_ms[expiry_order[live_count-1]] == 16'd0) begin
      s = int'(expiry_order[live_count-1]);
      live_count--;
      free_slots[s] = 1'b1;
      queue_report(KIND_EXPIRED, s[2:0], slot_label[s], 1'b0);
      n++;
    end
    if (n > 0) begin
      tail = pending_reports.pop_back();
      tail.last = 1'b1;
      pending_reports.push_back(tail);
    end
  endtask

  // compare result transfers first, then predict from the input transfer
  always @(posedge clk) begin
    out_item_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < SLOTS; i++) begin
        rel_ms[i]       = '0;
        expiry_order[i] = '0;
        slot_label[i]   = '0;
      end
      free_slots = '1;
      live_count = 0;
      pending_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d slot %0d",
                                    out_data.kind, out_data.slot));
        end else begin
          want = pending_reports.pop_front();
          if (out_data.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
          if (out_data.slot !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", out_data.slot, want.slot));
          if (out_data.expired_tag !== want.expired_tag)
            report_mismatch($sformatf("tag %h, expected %h",
                                      out_data.expired_tag, want.expired_tag));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_data.last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_START) predict_start(in_data.wait_time, in_data.tag);
        else predict_tick();
      end
    end
    outstanding <= pending_reports.size();
  end

endmodule

### tb/delta_list_timer_queue_unit_tb.sv
`timescale 1ns / 1ps

module delta_list_timer_queue_unit_tb;
  import dltq_pkg::*;

  localparam int SLOTS        = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 320;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_AFTER   = 100;
  localparam int HOLD_CYCLES  = 250;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        errors;
  int        outstanding;
  int        cycles;
  bit        calm;

  delta_list_timer_queue_unit #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  timer_queue_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (errors),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off to back up the block
  initial begin
    int  seen;
    bit  held;
    seen = 0;
    held = 1'b0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      if (!held && seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // offer one item, optionally after an idle burst, and hold it until the transfer
  task automatic offer(in_item_t item);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic start_timer(logic [15:0] wait_ms, logic [7:0] label);
    in_item_t item;
    item.cmd       = CMD_START;
    item.wait_time = wait_ms;
    item.tag       = label;
    offer(item);
  endtask

  task automatic tick_ms();
    in_item_t item;
    item.cmd       = CMD_TICK;
    item.wait_time = 16'($urandom_range(0, 65535));
    item.tag       = 8'($urandom_range(0, 255));
    offer(item);
  endtask

  // stop sending until every predicted result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    int          n;
    int          k;
    int          sel;
    logic [15:0] w;
    bit          paused;
    paused = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tick on an empty list, then a zero wait that expires on the next tick
    tick_ms();
    start_timer(16'd0, 8'hff);
    tick_ms();
    // equal expiries, a zero delta at the head and a tick with no expiry
    start_timer(16'd3, 8'h00);
    start_timer(16'd3, 8'h11);
    start_timer(16'd1, 8'h22);
    start_timer(16'd0, 8'h33);
    repeat (4) tick_ms();
    // fill every slot with the same expiry, overflow, then expire all in one tick
    for (k = 0; k < SLOTS; k++) start_timer(16'd2, 8'(8'hc0 + k));
    start_timer(16'hffff, 8'h5a);
    repeat (3) tick_ms();
    drain();

    // random mix of starts and ticks, mostly short waits so timers keep expiring
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (!paused && n >= RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        repeat (SLOTS + 1) start_timer(16'($urandom_range(0, 6)), 8'($urandom_range(0, 255)));
        n += SLOTS + 1;
      end else if (sel < 45) begin
        k = $urandom_range(0, 9);
        if (k < 5) w = 16'($urandom_range(0, 3));
        else if (k < 8) w = 16'($urandom_range(0, 12));
        else w = 16'($urandom_range(0, 40));
        start_timer(w, 8'($urandom_range(0, 255)));
        n++;
      end else begin
        tick_ms();
        n++;
      end
    end

    // far-future timers pin slots for the rest of the run
    start_timer(16'hffff, 8'h00);
    start_timer(16'haaaa, 8'hff);
    start_timer(16'h5555, 8'ha5);
    start_timer(16'h8000, 8'h5a);
    repeat (6) begin
      start_timer(16'($urandom_range(256, 65535)), 8'($urandom_range(0, 255)));
      tick_ms();
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
